[design/stree_pkg.sv]
// shared constants and types for the segment tree range max block
package stree_pkg;
    localparam int unsigned CAPACITY_DEF = 65536;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned RANGE_W = 17;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LEAF_WR,
        OP_PAIR_RD,
        OP_PARENT_WR,
        OP_Q_INIT,
        OP_Q_STEP,
        OP_Q_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic climb_done;
        logic q_done;
        logic out_busy;
    } t_status;
endpackage

[design/stree_ctrl.sv]
// controller state machine for the segment tree block
module stree_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_req_type,
    input  stree_pkg::t_status   i_status,
    output logic                 o_ready,
    output stree_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_WR    = 3'd2;
    localparam logic [2:0] S_QSTEP = 3'd3;
    localparam logic [2:0] S_QRES  = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE) && !i_status.out_busy;

    always_comb begin
        n_state = r_state;
        o_cmd.op = stree_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    if (i_req_type == stree_pkg::REQ_LOAD) begin
                        o_cmd.op = stree_pkg::OP_LEAF_WR;
                        n_state = S_RD;
                    end else begin
                        o_cmd.op = stree_pkg::OP_Q_INIT;
                        n_state = S_QSTEP;
                    end
                end
            end
            S_RD: begin
                if (i_status.climb_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = stree_pkg::OP_PAIR_RD;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.op = stree_pkg::OP_PARENT_WR;
                n_state = S_RD;
            end
            S_QSTEP: begin
                if (i_status.q_done) begin
                    n_state = S_QRES;
                end else begin
                    o_cmd.op = stree_pkg::OP_Q_STEP;
                end
            end
            S_QRES: begin
                o_cmd.op = stree_pkg::OP_Q_RESULT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> $past(r_state) == S_RD)
        else $error("parent write without pair read");
    a_res_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_QRES |-> $past(r_state) == S_QSTEP)
        else $error("result without query walk");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");
endmodule

[design/stree_dp.sv]
// datapath: tree memory, leaf climb and query walk registers, output word
module stree_dp #(
    parameter int unsigned CAPACITY = stree_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stree_pkg::t_cmd                   i_cmd,
    input  logic signed [stree_pkg::DATA_W-1:0] i_empty_value,
    input  logic signed [stree_pkg::DATA_W-1:0] i_element_value,
    input  logic                              i_last_element,
    input  logic [stree_pkg::RANGE_W-1:0]     i_range_start,
    input  logic [stree_pkg::RANGE_W-1:0]     i_range_stop,
    input  logic                              i_out_ready,
    output stree_pkg::t_status                o_status,
    output logic                              o_out_valid,
    output logic signed [stree_pkg::DATA_W-1:0] o_range_max,
    output logic                              o_range_empty
);
    localparam int unsigned LW = $clog2(CAPACITY);
    localparam int unsigned NW = LW + 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned DW = stree_pkg::DATA_W;
    localparam int unsigned RW = stree_pkg::RANGE_W;
    // walk pointers must hold stop + CAPACITY
    localparam int unsigned PW = ((RW > LW) ? RW : LW) + 2;

    // node 0 unused; two read ports, one write port
    logic signed [DW-1:0] r_mem [0:(2*CAPACITY)-1];

    logic [CW-1:0] r_count, r_pos;
    logic [NW-1:0] r_node;
    logic signed [DW-1:0] r_rd_a, r_rd_b;
    logic [NW-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic signed [DW-1:0] wr_data;
    logic wr_en;
    logic rd_en;

    logic [PW-1:0] r_l, r_r;
    logic r_found, r_qempty, r_phase;
    logic signed [DW-1:0] r_best;
    logic r_vl, r_vr;

    logic r_out_valid;
    logic signed [DW-1:0] r_out_max;
    logic r_out_empty;

    logic [PW-1:0] start_ext, stop_ext, cap_ext;
    logic q_bad;
    logic signed [DW-1:0] cand, best_a;
    logic found_a;

    assign cap_ext = PW'(CAPACITY);
    assign start_ext = PW'(i_range_start);
    assign stop_ext = PW'(i_range_stop);
    assign q_bad = (i_range_stop <= i_range_start) || (PW'(i_range_stop) > PW'(r_count));

    // memory ports
    always_comb begin
        wr_en = 1'b0;
        rd_en = 1'b0;
        wr_addr = r_node;
        wr_data = (r_rd_a < r_rd_b) ? r_rd_b : r_rd_a;
        rd_addr_a = {r_node[NW-2:0], 1'b0};
        rd_addr_b = {r_node[NW-2:0], 1'b1};
        unique case (i_cmd.op)
            stree_pkg::OP_LEAF_WR: begin
                wr_en = (r_pos < CW'(CAPACITY));
                wr_addr = NW'(r_pos) + NW'(CAPACITY);
                wr_data = i_element_value;
            end
            stree_pkg::OP_PAIR_RD: rd_en = 1'b1;
            stree_pkg::OP_PARENT_WR: wr_en = 1'b1;
            stree_pkg::OP_Q_STEP: begin
                rd_en = 1'b1;
                rd_addr_a = r_l[NW-1:0];
                rd_addr_b = NW'(r_r - PW'(1));
            end
            default: ;
        endcase
    end

    // read words are held until the next read so the last walk step survives
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    // fold the two words read in the previous walk step
    always_comb begin
        best_a = r_best;
        found_a = r_found;
        if (r_vl) begin
            best_a = (found_a && r_rd_a < best_a) ? best_a : r_rd_a;
            found_a = 1'b1;
        end
        cand = r_rd_b;
        if (r_vr) begin
            best_a = (found_a && cand < best_a) ? best_a : cand;
            found_a = 1'b1;
        end
    end

    // the root is node 1, so the climb ends once the pointer has passed it
    assign o_status.climb_done = (r_node == '0);
    assign o_status.q_done = r_qempty || (r_phase && !(r_l < r_r));
    assign o_status.out_busy = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos <= '0;
            r_node <= '0;
            r_out_valid <= 1'b0;
            r_vl <= 1'b0;
            r_vr <= 1'b0;
            r_phase <= 1'b0;
            r_qempty <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                stree_pkg::OP_LEAF_WR: begin
                    if (r_pos < CW'(CAPACITY)) begin
                        r_node <= (NW'(r_pos) + NW'(CAPACITY)) >> 1;
                        if (i_last_element) begin
                            r_count <= r_pos + CW'(1);
                            r_pos <= '0;
                        end else begin
                            r_pos <= r_pos + CW'(1);
                        end
                    end else begin
                        r_node <= '0;
                        if (i_last_element) begin
                            r_count <= r_pos;
                            r_pos <= '0;
                        end
                    end
                end
                stree_pkg::OP_PARENT_WR: r_node <= r_node >> 1;
                stree_pkg::OP_Q_INIT: begin
                    r_qempty <= q_bad;
                    r_l <= start_ext + cap_ext;
                    r_r <= stop_ext + cap_ext;
                    r_found <= 1'b0;
                    r_vl <= 1'b0;
                    r_vr <= 1'b0;
                    r_phase <= 1'b0;
                end
                stree_pkg::OP_Q_STEP: begin
                    // fold last step's reads, then issue this level's reads
                    r_best <= best_a;
                    r_found <= found_a;
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_vl <= 1'b0;
                        r_vr <= 1'b0;
                    end else begin
                        r_vl <= r_l[0];
                        r_vr <= r_r[0];
                        r_l <= (r_l + PW'(r_l[0])) >> 1;
                        r_r <= r_r >> 1;
                    end
                end
                stree_pkg::OP_Q_RESULT: begin
                    r_out_valid <= 1'b1;
                    r_out_empty <= r_qempty;
                    r_out_max <= r_qempty ? i_empty_value : best_a;
                    r_vl <= 1'b0;
                    r_vr <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_max = r_out_max;
    assign o_range_empty = r_out_empty;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_max))
        else $error("result word dropped");
    a_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node < NW'(CAPACITY))
        else $error("climb pointer outside internal nodes");
endmodule

[design/segment_tree_range_max.sv]
// Range-maximum segment tree over up to CAPACITY signed 32-bit elements held in one
// 2*CAPACITY-word memory. A load word first writes the leaf, then each ancestor is
// updated in two steps: one reads both children and one writes the maximum; a load
// beyond capacity writes nothing and updates no ancestor. A query walks one tree level
// per cycle with two memory reads; an empty or out-of-range query skips the walk and
// returns the empty value.
// One item is in work at a time; the result register frees the input side only once
// the previous result word has been taken.
module segment_tree_range_max #(
    parameter int unsigned CAPACITY = stree_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic signed [stree_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic signed [stree_pkg::DATA_W-1:0] i_element_value,
    input  logic                               i_last_element,
    input  logic [stree_pkg::RANGE_W-1:0]      i_range_start,
    input  logic [stree_pkg::RANGE_W-1:0]      i_range_stop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [stree_pkg::DATA_W-1:0] o_range_max,
    output logic                               o_range_empty
);
    logic signed [stree_pkg::DATA_W-1:0] r_empty_value;
    stree_pkg::t_cmd    cmd;
    stree_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_value <= '0;
        end else if (i_cfg_we) begin
            r_empty_value <= i_cfg_wdata;
        end
    end

    stree_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_req_type(i_req_type), .i_status(status), .o_ready(o_ready), .o_cmd(cmd)
    );

    stree_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_empty_value(r_empty_value), .i_element_value(i_element_value),
        .i_last_element(i_last_element), .i_range_start(i_range_start),
        .i_range_stop(i_range_stop), .i_out_ready(i_ready), .o_status(status),
        .o_out_valid(o_valid), .o_range_max(o_range_max), .o_range_empty(o_range_empty)
    );
endmodule

[dv/segment_tree_range_max_tb.sv]
// self-checking testbench for the segment tree range max block
`timescale 1ns / 100ps

module segment_tree_range_max_tb;
    localparam int unsigned CAP = stree_pkg::CAPACITY_DEF;
    localparam int unsigned STALL_LIMIT = 20000;

    class range_max_board;
        int signed node_val[int];
        int unsigned elem_count;
        int unsigned load_pos;
        logic signed [31:0] empty_val;
        logic signed [31:0] exp_max_q[$];
        logic exp_empty_q[$];
        int errors;

        function new();
            elem_count = 0;
            load_pos = 0;
            empty_val = 0;
            errors = 0;
        endfunction

        function int signed node_at(int unsigned n);
            if (node_val.exists(n)) return node_val[n];
            return 0;
        endfunction

        function void note_word(logic req, logic signed [31:0] val, logic last,
                                logic [16:0] start, logic [16:0] stop);
            int unsigned n;
            int unsigned l;
            int unsigned r;
            int signed best;
            bit found;
            int signed a;
            int signed b;
            if (req == stree_pkg::REQ_LOAD) begin
                if (load_pos < CAP) begin
                    n = load_pos + CAP;
                    node_val[n] = val;
                    while (n > 1) begin
                        n = n >> 1;
                        a = node_at(2 * n);
                        b = node_at(2 * n + 1);
                        node_val[n] = (a < b) ? b : a;
                    end
                    load_pos++;
                end
                if (last) begin
                    elem_count = load_pos;
                    load_pos = 0;
                end
            end else begin
                if (stop <= start || stop > elem_count) begin
                    exp_max_q.push_back(empty_val);
                    exp_empty_q.push_back(1'b1);
                end else begin
                    found = 0;
                    best = 0;
                    l = start + CAP;
                    r = stop + CAP;
                    while (l < r) begin
                        if (l & 1) begin
                            a = node_at(l);
                            best = (found && best > a) ? best : a;
                            found = 1;
                            l++;
                        end
                        if (r & 1) begin
                            r--;
                            a = node_at(r);
                            best = (found && best > a) ? best : a;
                            found = 1;
                        end
                        l = l >> 1;
                        r = r >> 1;
                    end
                    exp_max_q.push_back(best);
                    exp_empty_q.push_back(1'b0);
                end
            end
        endfunction

        function void check_result(logic signed [31:0] got_max, logic got_empty);
            logic signed [31:0] e_max;
            logic e_empty;
            if (exp_max_q.size() == 0) begin
                $display("%0t: unexpected result max=%0d empty=%0b", $time, got_max, got_empty);
                errors++;
                return;
            end
            e_max = exp_max_q.pop_front();
            e_empty = exp_empty_q.pop_front();
            if (got_max !== e_max) begin
                $display("%0t: range_max expected %0d actual %0d", $time, e_max, got_max);
                errors++;
            end
            if (got_empty !== e_empty) begin
                $display("%0t: range_empty expected %0b actual %0b", $time, e_empty, got_empty);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic signed [31:0] i_cfg_wdata;
    logic i_valid;
    logic o_ready;
    logic i_req_type;
    logic signed [31:0] i_element_value;
    logic i_last_element;
    logic [16:0] i_range_start;
    logic [16:0] i_range_stop;
    logic o_valid;
    logic i_ready;
    logic signed [31:0] o_range_max;
    logic o_range_empty;

    range_max_board board;
    bit calm;
    bit drive_done;
    int unsigned stall_cycles;
    int unsigned set_len;

    segment_tree_range_max uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_element_value(i_element_value),
        .i_last_element(i_last_element),
        .i_range_start(i_range_start), .i_range_stop(i_range_stop),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_range_max(o_range_max), .o_range_empty(o_range_empty)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random stalls, checks at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_range_max, o_range_empty);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("segment_tree_range_max_tb NOT OK");
            $finish;
        end
    end

    // valid stays high from one word to the next unless the sender idles
    task automatic send_word(logic req, logic signed [31:0] val, logic last,
                             logic [16:0] start, logic [16:0] stop);
        while (!calm && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_element_value <= val;
        i_last_element <= last;
        i_range_start <= start;
        i_range_stop <= stop;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_word(req, val, last, start, stop);
        @(negedge i_clk);
    endtask

    task automatic load_set(int unsigned n, bit wide);
        logic signed [31:0] v;
        for (int unsigned k = 0; k < n; k++) begin
            v = wide ? $urandom : $signed($urandom_range(40)) - 20;
            send_word(stree_pkg::REQ_LOAD, v, k == n - 1, 17'($urandom), 17'($urandom));
        end
    endtask

    task automatic query(logic [16:0] start, logic [16:0] stop);
        send_word(stree_pkg::REQ_QUERY, $urandom, 1'($urandom), start, stop);
    endtask

    task automatic rand_query();
        int unsigned a;
        int unsigned b;
        case ($urandom_range(9))
            0: query(17'($urandom), 17'($urandom));
            1: query(17'($urandom_range(set_len + 2)), 17'($urandom_range(set_len + 2)));
            default: begin
                a = $urandom_range(set_len > 0 ? set_len - 1 : 0);
                b = $urandom_range(set_len, a + 1);
                query(17'(a), 17'(b));
            end
        endcase
    endtask

    task automatic drain_and_set(logic signed [31:0] val);
        i_valid <= 1'b0;
        while (board.exp_max_q.size() != 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        board.empty_val = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        board = new();
        calm = 0;
        stall_cycles = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        i_valid = 0;
        i_ready = 0;
        i_req_type = stree_pkg::REQ_LOAD;
        i_element_value = 0;
        i_last_element = 0;
        i_range_start = 0;
        i_range_stop = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: queries with nothing loaded, extreme values, bounds
        query(0, 0);
        query(0, 1);
        send_word(stree_pkg::REQ_LOAD, 32'sh8000_0000, 1'b0, 17'h1ffff, 17'h1ffff);
        send_word(stree_pkg::REQ_LOAD, 32'sh7fff_ffff, 1'b0, 0, 0);
        send_word(stree_pkg::REQ_LOAD, -1, 1'b0, 0, 0);
        send_word(stree_pkg::REQ_LOAD, 0, 1'b1, 0, 0);
        set_len = 4;
        query(0, 1);
        query(0, 4);
        query(2, 4);
        query(3, 4);
        query(0, 5);
        query(2, 2);
        query(3, 1);
        query(17'h1ffff, 17'h1ffff);
        query(0, 17'h10000);
        drain_and_set(32'sh8000_0000);
        query(1, 1);
        query(4, 5);
        // partial reload: count keeps the old value meanwhile
        send_word(stree_pkg::REQ_LOAD, -5, 1'b0, 0, 0);
        query(0, 4);
        send_word(stree_pkg::REQ_LOAD, -7, 1'b1, 0, 0);
        set_len = 2;
        query(0, 2);
        query(0, 3);
        drain_and_set(32'sh7fff_ffff);
        query(5, 2);

        // random: many small sets, then one larger set
        for (int s = 0; s < 60; s++) begin
            if (s == 10) drain_and_set($urandom);
            if (s == 20) calm = 1;
            if (s == 35) calm = 0;
            if (s == 45) drain_and_set(0);
            set_len = $urandom_range(1, 12);
            load_set(set_len, 1'($urandom_range(1)));
            for (int q = 0; q < 8; q++) rand_query();
        end
        drain_and_set(-3);
        calm = 1;
        for (int unsigned k = 0; k < 64; k++)
            send_word(stree_pkg::REQ_LOAD, $urandom, k == 63, 0, 0);
        calm = 0;
        set_len = 64;
        query(0, 17'h10000);
        query(17'hffff, 17'h10000);
        query(0, 17'h10001);
        query(0, 64);
        for (int q = 0; q < 40; q++) rand_query();

        i_valid <= 1'b0;
        while (board.exp_max_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0)
            $display("segment_tree_range_max_tb OK");
        else
            $display("segment_tree_range_max_tb NOT OK");
        $finish;
    end
endmodule

[files.f]
design/stree_pkg.sv
design/stree_ctrl.sv
design/stree_dp.sv
design/segment_tree_range_max.sv
dv/segment_tree_range_max_tb.sv
